// ----- rtl/max_pool_with_argmax_defines.svh -----
// Assertion macros used by the max pooling back end (mpa_back).
`ifndef MAX_POOL_WITH_ARGMAX_DEFINES_SVH
`define MAX_POOL_WITH_ARGMAX_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define MPA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define MPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mpa_pkg.sv -----
// Types and constants shared by the max pooling with argmax block.
`default_nettype none
package mpa_pkg;

    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 22;
    localparam int PLANE_W  = 16;
    localparam int OROW_W   = 12;
    localparam int OCOL_W   = 10;
    localparam int R_W      = 13;  // input row coordinate
    localparam int C_W      = 11;  // input column coordinate
    localparam int IQ_W     = 14;  // window row index
    localparam int JQ_W     = 12;  // window column index
    localparam int K_W      = 4;
    localparam int CFG_W    = 13;

    typedef enum logic [2:0] {
        CFG_IN_WIDTH    = 3'd0,
        CFG_IN_HEIGHT   = 3'd1,
        CFG_WINDOW_SIZE = 3'd2,
        CFG_STRIDE      = 3'd3,
        CFG_PAD_TOTAL   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RD,
        B_WR,
        B_FL
    } t_bstate;

    // clamped geometry
    typedef struct packed {
        logic [C_W-1:0] w;
        logic [R_W-1:0] h;
        logic [K_W-1:0] k;
        logic [K_W-1:0] s;
        logic [2:0]     p;
        logic [1:0]     off;
    } t_geom;

    // one classified sample
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] v;
        logic [R_W-1:0]             r;
        logic [C_W-1:0]             c;
        logic [PLANE_W-1:0]         plane;
        logic [POS_W-1:0]           pos;
        logic [IQ_W-1:0]            ilo;
        logic [IQ_W-1:0]            ihi;
        logic [JQ_W-1:0]            jlo;
        logic [JQ_W-1:0]            jhi;
        logic                       none;
    } t_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] maxv;
        logic                       found;
        logic [POS_W-1:0]           pos;
    } t_acc;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] maxv;
        logic                       found;
        logic [POS_W-1:0]           pos;
        logic [PLANE_W-1:0]         plane;
        logic [OROW_W-1:0]          orow;
        logic [OCOL_W-1:0]          ocol;
        logic                       last;
    } t_res;

endpackage
`default_nettype wire

// ----- rtl/max_pool_with_argmax.sv -----
// Top level: streaming 2-D max pooling with argmax.
//
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_stall         i_sample
//  output    out        o_valid / i_stall         o_max_value .. o_last_of_run
//  config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// Flow: the front takes one sample per cycle into a 4-deep queue while that
// queue is not full. The back picks up a sample, then reads and then updates
// the accumulator for each window the sample touches, up to 64 windows, and
// last hands over the final result; the single-port accumulator RAM sets this.
// A transaction touching no window is dropped at pickup.
// Reset: synchronous, active low; counters and queues clear, no RAM sweep
// (every accumulator is seeded at its window's first sample).
// Stalls: results wait in a 4-deep output queue; the back halts when it fills,
// and the input stalls when the item queue fills.
`default_nettype none
module max_pool_with_argmax #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_WINDOW = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [mpa_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                 i_cfg_we,
    input  logic [2:0]                           i_cfg_idx,
    input  logic [mpa_pkg::CFG_W-1:0]            i_cfg_data,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [mpa_pkg::SAMPLE_W-1:0]  o_max_value,
    output logic                                 o_found,
    output logic [mpa_pkg::POS_W-1:0]            o_source_pos,
    output logic [mpa_pkg::PLANE_W-1:0]          o_plane,
    output logic [mpa_pkg::OROW_W-1:0]           o_out_row,
    output logic [mpa_pkg::OCOL_W-1:0]           o_out_col,
    output logic                                 o_last_of_run
);
    import mpa_pkg::*;

    localparam int QDEPTH = 4;

    // configuration registers
    logic [10:0] r_in_width;
    logic [12:0] r_in_height;
    logic [3:0]  r_window;
    logic [3:0]  r_stride;
    logic [2:0]  r_pad;
    logic        w_restart;
    t_geom       w_geom;

    // queues
    t_item w_f_item, w_b_item;
    logic  w_f_push, w_iq_full, w_iq_empty, w_b_pop;
    t_res  w_b_res, w_out;
    logic  w_b_push, w_oq_full, w_oq_empty;

    // any write to a known register restarts the plane
    always_comb begin
        case (i_cfg_idx)
            CFG_IN_WIDTH, CFG_IN_HEIGHT, CFG_WINDOW_SIZE, CFG_STRIDE, CFG_PAD_TOTAL:
                w_restart = i_cfg_we;
            default: w_restart = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width  <= 11'd1;
            r_in_height <= 13'd1;
            r_window    <= 4'd2;
            r_stride    <= 4'd2;
            r_pad       <= 3'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IN_WIDTH:    r_in_width  <= i_cfg_data[10:0];
                CFG_IN_HEIGHT:   r_in_height <= i_cfg_data[12:0];
                CFG_WINDOW_SIZE: r_window    <= i_cfg_data[3:0];
                CFG_STRIDE:      r_stride    <= i_cfg_data[3:0];
                CFG_PAD_TOTAL:   r_pad       <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // clamp geometry: zero and oversize fields, pad capped at k-1
    always_comb begin
        if (r_in_width == '0) begin
            w_geom.w = 11'd1;
        end else if ({2'b0, r_in_width} > 13'(MAX_WIDTH)) begin
            w_geom.w = 11'(MAX_WIDTH);
        end else begin
            w_geom.w = r_in_width;
        end
        if (r_in_height == '0) begin
            w_geom.h = 13'd1;
        end else if ({4'b0, r_in_height} > 17'(MAX_HEIGHT)) begin
            w_geom.h = 13'(MAX_HEIGHT);
        end else begin
            w_geom.h = r_in_height;
        end
        if (r_window == '0) begin
            w_geom.k = 4'd1;
        end else if (r_window > 4'(MAX_WINDOW)) begin
            w_geom.k = 4'(MAX_WINDOW);
        end else begin
            w_geom.k = r_window;
        end
        w_geom.s   = (r_stride == '0) ? 4'd1 : r_stride;
        w_geom.p   = ({1'b0, r_pad} > (w_geom.k - 4'd1)) ? 3'(w_geom.k - 4'd1) : r_pad;
        w_geom.off = w_geom.p[2:1];
    end

    mpa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (w_geom),
        .i_restart (w_restart),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_sample  (i_sample),
        .o_push    (w_f_push),
        .o_item    (w_f_item),
        .i_full    (w_iq_full)
    );

    mpa_fifo #(.W($bits(t_item)), .DEPTH(QDEPTH)) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_push),
        .i_data  (w_f_item),
        .i_pop   (w_b_pop),
        .o_data  (w_b_item),
        .o_full  (w_iq_full),
        .o_empty (w_iq_empty)
    );

    mpa_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (w_geom),
        .i_empty (w_iq_empty),
        .i_item  (w_b_item),
        .o_pop   (w_b_pop),
        .i_full  (w_oq_full),
        .o_push  (w_b_push),
        .o_res   (w_b_res)
    );

    mpa_fifo #(.W($bits(t_res)), .DEPTH(QDEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_b_push),
        .i_data  (w_b_res),
        .i_pop   (!i_stall),
        .o_data  (w_out),
        .o_full  (w_oq_full),
        .o_empty (w_oq_empty)
    );

    assign o_valid       = !w_oq_empty;
    assign o_max_value   = w_out.maxv;
    assign o_found       = w_out.found;
    assign o_source_pos  = w_out.pos;
    assign o_plane       = w_out.plane;
    assign o_out_row     = w_out.orow;
    assign o_out_col     = w_out.ocol;
    assign o_last_of_run = w_out.last;
endmodule
`default_nettype wire

// ----- rtl/mpa_fifo.sv -----
// Small register FIFO with show-ahead head.
`default_nettype none
module mpa_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;
    logic          w_do_push, w_do_pop;

    assign o_full    = (r_cnt == NW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/mpa_front.sv -----
// Front end: raster counters and the range of windows each sample touches.
`default_nettype none
module mpa_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mpa_pkg::t_geom                i_geom,
    input  logic                          i_restart,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [mpa_pkg::SAMPLE_W-1:0] i_sample,
    output logic                          o_push,
    output mpa_pkg::t_item                o_item,
    input  logic                          i_full
);
    import mpa_pkg::*;

    logic [C_W-1:0]     r_c;
    logic [R_W-1:0]     r_r;
    logic [PLANE_W-1:0] r_plane;
    logic [JQ_W-1:0]    r_cq;
    logic [2:0]         r_cph;
    logic [IQ_W-1:0]    r_rq;
    logic [2:0]         r_rph;

    logic [1:0]      w_q0;
    logic [2:0]      w_ph0;
    logic [JQ_W-1:0] w_cq;
    logic [2:0]      w_cph;
    logic [IQ_W-1:0] w_rq;
    logic [2:0]      w_rph;
    logic [3:0]      w_ccnt, w_rcnt;
    logic [23:0]     w_prod;
    logic            w_acc, w_cend, w_rend;

    // windows m steps back from the last one still hold the sample
    function automatic logic [3:0] f_cnt(input logic [2:0] ph, input logic [IQ_W-1:0] q,
                                         input logic [K_W-1:0] s, input logic [K_W-1:0] k);
        logic [3:0] cnt;
        logic [6:0] ms;
        cnt = '0;
        for (int m = 0; m < 8; m++) begin
            ms = 7'(m * s);
            if ((ms + 7'(ph)) <= 7'(k - 1'b1) && IQ_W'(m) <= q) begin
                cnt = cnt + 1'b1;
            end
        end
        return cnt;
    endfunction

    // off / s and off % s for off <= 3
    always_comb begin
        case (i_geom.s)
            4'd1: begin
                w_q0  = i_geom.off;
                w_ph0 = '0;
            end
            4'd2: begin
                w_q0  = {1'b0, i_geom.off[1]};
                w_ph0 = {2'b0, i_geom.off[0]};
            end
            4'd3: begin
                w_q0  = (i_geom.off == 2'd3) ? 2'd1 : 2'd0;
                w_ph0 = (i_geom.off == 2'd3) ? 3'd0 : {1'b0, i_geom.off};
            end
            default: begin
                w_q0  = '0;
                w_ph0 = {1'b0, i_geom.off};
            end
        endcase
    end

    assign w_cq  = (r_c == '0) ? JQ_W'(w_q0) : r_cq;
    assign w_cph = (r_c == '0) ? w_ph0 : r_cph;
    assign w_rq  = (r_r == '0) ? IQ_W'(w_q0) : r_rq;
    assign w_rph = (r_r == '0) ? w_ph0 : r_rph;

    assign w_ccnt = f_cnt(w_cph, IQ_W'(w_cq), i_geom.s, i_geom.k);
    assign w_rcnt = f_cnt(w_rph, w_rq, i_geom.s, i_geom.k);
    assign w_prod = r_r * i_geom.w;

    assign o_stall = i_full;
    assign w_acc   = i_valid && !i_full;
    assign o_push  = w_acc;
    assign w_cend  = (C_W'(r_c + 1'b1) == i_geom.w);
    assign w_rend  = (R_W'(r_r + 1'b1) == i_geom.h);

    always_comb begin
        o_item.v     = i_sample;
        o_item.r     = r_r;
        o_item.c     = r_c;
        o_item.plane = r_plane;
        o_item.pos   = POS_W'(w_prod + 24'(r_c));
        o_item.ihi   = w_rq;
        o_item.ilo   = w_rq - IQ_W'(w_rcnt) + IQ_W'(1);
        o_item.jhi   = w_cq;
        o_item.jlo   = w_cq - JQ_W'(w_ccnt) + JQ_W'(1);
        o_item.none  = (w_rcnt == '0) || (w_ccnt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c     <= '0;
            r_r     <= '0;
            r_plane <= '0;
            r_cq    <= '0;
            r_cph   <= '0;
            r_rq    <= '0;
            r_rph   <= '0;
        end else if (i_restart) begin
            r_c <= '0;
            r_r <= '0;
        end else if (w_acc) begin
            if (w_cend) begin
                r_c <= '0;
                if (w_rend) begin
                    r_r     <= '0;
                    r_plane <= r_plane + 1'b1;
                end else begin
                    r_r <= r_r + 1'b1;
                    if (({1'b0, w_rph} + 4'd1) == i_geom.s) begin
                        r_rq  <= w_rq + 1'b1;
                        r_rph <= '0;
                    end else begin
                        r_rq  <= w_rq;
                        r_rph <= w_rph + 1'b1;
                    end
                end
            end else begin
                r_c <= r_c + 1'b1;
                if (({1'b0, w_cph} + 4'd1) == i_geom.s) begin
                    r_cq  <= w_cq + 1'b1;
                    r_cph <= '0;
                end else begin
                    r_cq  <= w_cq;
                    r_cph <= w_cph + 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/mpa_back.sv -----
// Back end: per-window accumulator update and result emission.
`default_nettype none
`include "max_pool_with_argmax_defines.svh"
module mpa_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mpa_pkg::t_geom i_geom,
    input  logic           i_empty,
    input  mpa_pkg::t_item i_item,
    output logic           o_pop,
    input  logic           i_full,
    output logic           o_push,
    output mpa_pkg::t_res  o_res
);
    import mpa_pkg::*;

    localparam int RB    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CB    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DEPTH = 2 ** (RB + CB);

    t_acc          r_mem [DEPTH];
    t_bstate       r_st, n_st;
    t_item         r_it;
    logic [IQ_W-1:0] r_i;
    logic [JQ_W-1:0] r_j;
    logic          r_init, r_emit, r_ok;
    t_acc          r_rd;
    logic          r_pend_v;
    t_res          r_pend;

    logic [RB+CB-1:0]   w_addr;
    logic [19:0]        w_is, w_js;
    logic signed [19:0] w_rs, w_cs, w_rl, w_cl, w_hm1, w_wm1, w_r, w_c;
    logic               w_init, w_emit, w_ok;
    t_acc               w_base, w_upd;
    t_res               w_rec;
    logic               w_hit, w_blk, w_done;

    assign w_addr = {r_i[RB-1:0], r_j[CB-1:0]};

    // window geometry for the current (i, j)
    always_comb begin
        w_is   = 20'(r_i * i_geom.s);
        w_js   = 20'(r_j * i_geom.s);
        w_rs   = $signed(w_is) - $signed(20'(i_geom.off));
        w_cs   = $signed(w_js) - $signed(20'(i_geom.off));
        w_rl   = w_rs + $signed(20'(i_geom.k)) - 20'sd1;
        w_cl   = w_cs + $signed(20'(i_geom.k)) - 20'sd1;
        w_hm1  = $signed(20'(i_geom.h)) - 20'sd1;
        w_wm1  = $signed(20'(i_geom.w)) - 20'sd1;
        w_r    = $signed(20'(r_it.r));
        w_c    = $signed(20'(r_it.c));
        w_init = ((w_rs <= 0) ? (w_r == 0) : (w_r == w_rs))
              && ((w_cs <= 0) ? (w_c == 0) : (w_c == w_cs));
        w_emit = ((w_rl >= w_hm1) ? (w_r == w_hm1) : (w_r == w_rl))
              && ((w_cl >= w_wm1) ? (w_c == w_wm1) : (w_c == w_cl));
        w_ok   = ((w_is + 20'(i_geom.k)) <= (20'(i_geom.h) + 20'(i_geom.p)))
              && ((w_js + 20'(i_geom.k)) <= (20'(i_geom.w) + 20'(i_geom.p)));
    end

    always_comb begin
        if (r_init) begin
            w_base.maxv  = 16'sh8000;
            w_base.found = 1'b0;
            w_base.pos   = '0;
        end else begin
            w_base = r_rd;
        end
        if (r_it.v > w_base.maxv) begin
            w_upd.maxv  = r_it.v;
            w_upd.found = 1'b1;
            w_upd.pos   = r_it.pos;
        end else begin
            w_upd = w_base;
        end
        w_rec.maxv  = w_upd.maxv;
        w_rec.found = w_upd.found;
        w_rec.pos   = w_upd.pos;
        w_rec.plane = r_it.plane;
        w_rec.orow  = OROW_W'(r_i);
        w_rec.ocol  = OCOL_W'(r_j);
        w_rec.last  = 1'b0;
    end

    assign w_hit  = r_ok && r_emit;
    assign w_blk  = w_hit && r_pend_v && i_full;
    assign w_done = (r_i == r_it.ihi) && (r_j == r_it.jhi);

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            B_IDLE: if (!i_empty && !i_item.none) n_st = B_RD;
            B_RD:   n_st = B_WR;
            B_WR: begin
                if (!w_blk) n_st = w_done ? B_FL : B_RD;
            end
            B_FL:   if (!r_pend_v || !i_full) n_st = B_IDLE;
            default: n_st = B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop  = 1'b0;
        o_push = 1'b0;
        o_res  = r_pend;
        case (r_st)
            B_IDLE: o_pop = !i_empty;
            B_WR:   o_push = w_hit && r_pend_v && !i_full;
            B_FL: begin
                o_push     = r_pend_v && !i_full;
                o_res.last = 1'b1;
            end
            default: o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == B_RD) begin
            r_rd <= r_mem[w_addr];
        end
        if (r_st == B_WR && r_ok) begin
            r_mem[w_addr] <= w_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == B_IDLE && !i_empty) begin
            r_it <= i_item;
            r_i  <= i_item.ilo;
            r_j  <= i_item.jlo;
        end
        if (r_st == B_RD) begin
            r_init <= w_init;
            r_emit <= w_emit;
            r_ok   <= w_ok;
        end
        if (r_st == B_WR && !w_blk) begin
            if (r_j == r_it.jhi) begin
                r_j <= r_it.jlo;
                r_i <= r_i + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
            if (w_hit) begin
                r_pend <= w_rec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= B_IDLE;
            r_pend_v <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == B_WR && !w_blk && w_hit) begin
                r_pend_v <= 1'b1;
            end else if (r_st == B_FL && !i_full) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    `MPA_ASSERT_SAME(a_idle_no_pend, r_st == B_IDLE, !r_pend_v, "result left pending at idle")
    `MPA_ASSERT_NEXT(a_rd_then_wr, r_st == B_RD, r_st == B_WR, "read not followed by update")
    `MPA_ASSERT_NEXT(a_hit_pends, (r_st == B_WR) && w_hit && !w_blk, r_pend_v,
                     "emitted window not held")
endmodule
`default_nettype wire

// ----- tb/max_pool_checker.sv -----
// Checker for max_pool_with_argmax: predicts pooled results and compares them.
`timescale 1ns / 100ps
module max_pool_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_in_stall,
    input  logic signed [mpa_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_cfg_we,
    input  logic [2:0]                          i_cfg_idx,
    input  logic [mpa_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [mpa_pkg::SAMPLE_W-1:0] i_max_value,
    input  logic                                i_found,
    input  logic [mpa_pkg::POS_W-1:0]           i_source_pos,
    input  logic [mpa_pkg::PLANE_W-1:0]         i_plane,
    input  logic [mpa_pkg::OROW_W-1:0]          i_out_row,
    input  logic [mpa_pkg::OCOL_W-1:0]          i_out_col,
    input  logic                                i_last_of_run,
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_results
);
    import mpa_pkg::*;

    localparam int ACC_N = 8 * 1024;

    t_res pooled_q[$];

    logic signed [15:0] acc_max [ACC_N];
    bit                 acc_found [ACC_N];
    int                 acc_pos [ACC_N];

    int cfg_w, cfg_h, cfg_k, cfg_s, cfg_p;
    int row_cnt, col_cnt;
    logic [15:0] plane_cnt;

    function automatic int win_count(int n, int p, int k, int s);
        if (n + p < k) return 0;
        return (n + p - k) / s + 1;
    endfunction

    function automatic void pool_sample(logic signed [15:0] x);
        int w, h, k, s, p, off, ow, oh, r, c, t;
        int ilo, ihi, jlo, jhi, rs, rf, rl, cs, cf, cl, ai;
        t_res e;
        t_res burst[$];
        w = (cfg_w < 1) ? 1 : (cfg_w > 1024 ? 1024 : cfg_w);
        h = (cfg_h < 1) ? 1 : (cfg_h > 4096 ? 4096 : cfg_h);
        k = (cfg_k < 1) ? 1 : (cfg_k > 8 ? 8 : cfg_k);
        s = (cfg_s == 0) ? 1 : cfg_s;
        p = (cfg_p > k - 1) ? k - 1 : cfg_p;
        off = p / 2;
        ow = win_count(w, p, k, s);
        oh = win_count(h, p, k, s);
        r = row_cnt;
        c = col_cnt;
        if (r >= h || c >= w) begin
            r = 0;
            c = 0;
        end
        if (ow > 0 && oh > 0) begin
            t = r + off - k + 1;
            ilo = (t <= 0) ? 0 : (t + s - 1) / s;
            ihi = (r + off) / s;
            if (ihi > oh - 1) ihi = oh - 1;
            t = c + off - k + 1;
            jlo = (t <= 0) ? 0 : (t + s - 1) / s;
            jhi = (c + off) / s;
            if (jhi > ow - 1) jhi = ow - 1;
            for (int i = ilo; i <= ihi; i++) begin
                rs = i * s - off;
                rf = rs < 0 ? 0 : rs;
                rl = (rs + k - 1 > h - 1) ? h - 1 : rs + k - 1;
                for (int j = jlo; j <= jhi; j++) begin
                    cs = j * s - off;
                    cf = cs < 0 ? 0 : cs;
                    cl = (cs + k - 1 > w - 1) ? w - 1 : cs + k - 1;
                    ai = (i % 8) * 1024 + j;
                    if (ai < ACC_N) begin
                        if (r == rf && c == cf) begin
                            acc_max[ai] = -16'sd32768;
                            acc_found[ai] = 0;
                            acc_pos[ai] = 0;
                        end
                        if (x > acc_max[ai]) begin
                            acc_max[ai] = x;
                            acc_found[ai] = 1;
                            acc_pos[ai] = r * w + c;
                        end
                        if (r == rl && c == cl && burst.size() < 64) begin
                            e.maxv  = acc_max[ai];
                            e.found = acc_found[ai];
                            e.pos   = acc_pos[ai][POS_W-1:0];
                            e.plane = plane_cnt;
                            e.orow  = i[OROW_W-1:0];
                            e.ocol  = j[OCOL_W-1:0];
                            e.last  = 1'b0;
                            burst.push_back(e);
                        end
                    end
                end
            end
        end
        if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
        foreach (burst[n]) pooled_q.push_back(burst[n]);
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) begin
                r = 0;
                plane_cnt++;
            end
        end
        row_cnt = r;
        col_cnt = c;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name,
                     exp_v, act_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            pooled_q.delete();
            row_cnt = 0;
            col_cnt = 0;
            plane_cnt = '0;
            cfg_w = 1;
            cfg_h = 1;
            cfg_k = 2;
            cfg_s = 2;
            cfg_p = 0;
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (i_cfg_we && i_cfg_idx <= CFG_PAD_TOTAL) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_IN_WIDTH:    cfg_w = i_cfg_data[10:0];
                    CFG_IN_HEIGHT:   cfg_h = i_cfg_data[12:0];
                    CFG_WINDOW_SIZE: cfg_k = i_cfg_data[3:0];
                    CFG_STRIDE:      cfg_s = i_cfg_data[3:0];
                    default:         cfg_p = i_cfg_data[2:0];
                endcase
                row_cnt = 0;
                col_cnt = 0;
            end
            if (i_valid && !i_in_stall) pool_sample(i_sample);
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (pooled_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual max %0d at %0d",
                             $time, i_max_value, i_source_pos);
                    o_errors++;
                end else begin
                    e = pooled_q.pop_front();
                    check_field("max_value", e.maxv, i_max_value);
                    check_field("found", e.found, i_found);
                    check_field("source_pos", e.pos, i_source_pos);
                    check_field("plane", e.plane, i_plane);
                    check_field("out_row", e.orow, i_out_row);
                    check_field("out_col", e.ocol, i_out_col);
                    check_field("last_of_run", e.last, i_last_of_run);
                end
            end
        end
        o_pending <= pooled_q.size();
    end
endmodule

// ----- tb/tb_max_pool_with_argmax.sv -----
// Top level of the max_pool_with_argmax testbench: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module tb_max_pool_with_argmax;
    import mpa_pkg::*;

    // Index beyond the register map; such a write must be ignored.
    localparam logic [2:0] CFG_IDX_UNUSED = 3'd7;
    // Cycles without any transaction before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 20000;
    // Quiet time that covers the back end finishing every queued no-result sample
    // (item queue plus the one in the back).
    localparam int DRAIN_CYCLES = 800;
    // Samples per idling phase.
    localparam int PHASE_SAMPLES = 34;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic signed [15:0]   i_sample = '0;
    logic                 i_cfg_we = 1'b0;
    logic [2:0]           i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_stall = 1'b0;
    logic                 o_stall, o_valid, o_found, o_last_of_run;
    logic signed [15:0]   o_max_value;
    logic [POS_W-1:0]     o_source_pos;
    logic [PLANE_W-1:0]   o_plane;
    logic [OROW_W-1:0]    o_out_row;
    logic [OCOL_W-1:0]    o_out_col;

    int errors, pending, results;
    int src_idle = 0;        // percent of cycles the sender holds off
    int snk_stall = 0;       // percent of cycles the receiver stalls
    int samples_sent = 0;
    int configs_done = 0;
    int quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    max_pool_with_argmax DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_sample(i_sample),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_max_value(o_max_value), .o_found(o_found), .o_source_pos(o_source_pos),
        .o_plane(o_plane), .o_out_row(o_out_row), .o_out_col(o_out_col),
        .o_last_of_run(o_last_of_run)
    );

    max_pool_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_in_stall(o_stall), .i_sample(i_sample),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_max_value(o_max_value), .i_found(o_found), .i_source_pos(o_source_pos),
        .i_plane(o_plane), .i_out_row(o_out_row), .i_out_col(o_out_col),
        .i_last_of_run(o_last_of_run),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge i_clk) i_stall <= ($urandom_range(99) < snk_stall);

    // Watchdog: any cycle with a transaction on either channel or a register
    // write counts as progress.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One sample transaction; valid stays up across back-to-back samples.
    task automatic send_sample(input logic signed [15:0] v);
        while ($urandom_range(99) < src_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        samples_sent++;
    endtask

    // Let every pending result drain, then give the back end time to go idle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Full geometry update, only ever issued with the block idle.
    task automatic set_geometry(input int w, input int h, input int k, input int s,
                                input int p);
        wait_idle();
        write_reg(CFG_IN_WIDTH, CFG_W'(w));
        write_reg(CFG_IN_HEIGHT, CFG_W'(h));
        write_reg(CFG_WINDOW_SIZE, CFG_W'(k));
        write_reg(CFG_STRIDE, CFG_W'(s));
        write_reg(CFG_PAD_TOTAL, CFG_W'(p));
        @(posedge i_clk);
        configs_done++;
    endtask

    // Mostly random content, with the occasional extreme value mixed in.
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(9))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        int w, h, budget;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry is 1x1 with a 2x2 window: no window fits, no results.
        send_sample(16'sd5);
        send_sample(-16'sd7);

        // Plain 4x4 plane, 2x2 windows, extremes and ties.
        set_geometry(4, 4, 2, 2, 0);
        send_sample(16'sd32767);  send_sample(-16'sd32768);
        send_sample(16'sd0);      send_sample(-16'sd1);
        send_sample(16'sd32767);  send_sample(16'sd32767);
        send_sample(-16'sd1);     send_sample(16'sd0);
        for (int n = 0; n < 8; n++) send_sample(-16'sd32768);

        // Padded 3x3 window with stride 1: padding must never win.
        set_geometry(3, 3, 3, 1, 2);
        for (int n = 0; n < 9; n++) send_sample(16'(-32768 + n * 3));

        // Zero geometry clamps to 1x1, window 1, stride 1; oversized pad cut.
        set_geometry(0, 0, 0, 0, 7);
        send_sample(16'sd100);
        send_sample(-16'sd32768);

        // Oversized values clamp to the maximum geometry.
        set_geometry(2047, 8191, 15, 15, 7);
        send_sample(16'sd1);
        // A write to an unused index is dropped but still a quiet-time write.
        wait_idle();
        write_reg(CFG_IDX_UNUSED, '1);
        set_geometry(1024, 1, 1, 1, 0);
        for (int n = 0; n < 3; n++) send_sample(pick_sample());

        // Random geometries, one idling mix per phase.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 50; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 50; end
                default: begin src_idle = 24; snk_stall = 24; end
            endcase
            budget = samples_sent + PHASE_SAMPLES;
            while (samples_sent < budget) begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 6);
                set_geometry(w, h, $urandom_range(1, 8), $urandom_range(0, 8),
                             $urandom_range(0, 7));
                // A full plane and sometimes part of the next, cut short at the phase budget.
                for (int n = $urandom_range(w * h, 2 * w * h);
                     n > 0 && samples_sent < budget; n--)
                    send_sample(pick_sample());
            end
        end

        wait_idle();
        $display("Covered %0d samples and %0d pooled results over %0d geometries,",
                 samples_sent, results, configs_done);
        $display("with clamped, padded and empty-window setups under mixed back-pressure.");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mpa_pkg.sv
rtl/mpa_fifo.sv
rtl/mpa_front.sv
rtl/mpa_back.sv
rtl/max_pool_with_argmax.sv
tb/max_pool_checker.sv
tb/tb_max_pool_with_argmax.sv
